### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each takes a label, an antecedent, a consequent and a message; clk and rst_n
// must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    spq_op_t           operation;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;
  } spq_in_t;

  typedef struct packed {
    spq_status_t       status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]  occupancy;
  } spq_out_t;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } spq_ctl_t;

endpackage

### hdl/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctl_t  ctl,
  input  logic               occ,
  input  spq_pkg::spq_entry_t new_entry,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic               left_keep,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic               keep
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;

  // Hold the entry when it is held and ranks equal or above the newcomer.
  assign keep  = occ && (entry_r.prio >= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.shift_out) begin
      entry_nxt = right_entry;
    end else if (ctl.shift_in && !keep) begin
      // First cell behind the kept run takes the newcomer, the rest advance.
      entry_nxt = left_keep ? new_entry : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### hdl/stable_priority_queue.sv
// Sorted ready queue: entries ordered by priority, highest first, ties in
// arrival order.
// Input channel (in_valid / in_stall / in_data): one transaction is either an
// enqueue of (proc_id, prio) or a dequeue of the head entry.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// input transaction, carrying status, the removed entry on a successful
// dequeue (zero otherwise) and the occupancy after the transaction.
// The result is registered and presented in the cycle after acceptance.
// Throughput: one transaction per cycle unless the input is stalled; the row
// of cells inserts or removes an entry at once, each cell comparing its own
// priority in parallel. A full queue drops an enqueue with status FULL; an
// empty queue answers a dequeue with status EMPTY. Neither changes the queue.
// Reset empties the queue at once (occupancy count cleared) and drops any
// pending result; cell contents are not cleared and are never read before
// being written.
// While the receiver stalls a waiting result, the result register holds and
// the input is stalled until the result is taken.
module stable_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);

  logic [spq_pkg::CNT_W-1:0] count_r;
  logic [spq_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  spq_pkg::spq_out_t         out_data_r;
  spq_pkg::spq_out_t         out_data_nxt;

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic                 do_enq;
  logic                 do_deq;
  spq_pkg::spq_ctl_t    ctl;
  spq_pkg::spq_entry_t  new_entry;

  spq_pkg::spq_entry_t  entry_w [spq_pkg::DEPTH];
  logic                 keep_w  [spq_pkg::DEPTH];
  logic                 occ_w   [spq_pkg::DEPTH];

  // Accept whenever the result register is free or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full  = (count_r == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  assign do_enq   = accept && (in_data.operation == spq_pkg::OP_ENQ) && !is_full;
  assign do_deq   = accept && (in_data.operation == spq_pkg::OP_DEQ) && !is_empty;

  assign ctl.shift_in  = do_enq;
  assign ctl.shift_out = do_deq;
  assign new_entry.id   = in_data.proc_id;
  assign new_entry.prio = in_data.prio;

  // Row of cells, head at index 0.
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::spq_entry_t left_entry;
    spq_pkg::spq_entry_t right_entry;
    logic                left_keep;

    assign occ_w[i] = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = entry_w[i-1];
      assign left_keep  = keep_w[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_entry = entry_w[i];
    end else begin : g_mid
      assign right_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ_w[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (entry_w[i]),
      .keep        (keep_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + spq_pkg::CNT_W'(1);
    end else if (do_deq) begin
      count_nxt = count_r - spq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_data_nxt           = out_data_r;
    if (accept) begin
      out_data_nxt.status    = spq_pkg::ST_OK;
      out_data_nxt.out_id    = '0;
      out_data_nxt.out_prio  = '0;
      out_data_nxt.occupancy = spq_pkg::OCC_W'(count_nxt);
      unique case (in_data.operation)
        spq_pkg::OP_ENQ: begin
          if (is_full) begin
            out_data_nxt.status = spq_pkg::ST_FULL;
          end
        end
        spq_pkg::OP_DEQ: begin
          if (is_empty) begin
            out_data_nxt.status = spq_pkg::ST_EMPTY;
          end else begin
            out_data_nxt.out_id   = entry_w[0].id;
            out_data_nxt.out_prio = entry_w[0].prio;
          end
        end
        default: begin
          out_data_nxt.status = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/spq_checker.sv
`include "assert_macros.svh"

module spq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input spq_pkg::spq_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input spq_pkg::spq_out_t out_data
);

  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `SPQ_ASSERT_SAME(a_no_overrun, in_valid && !in_stall, !(out_valid && out_stall), "transaction accepted over a stalled result")

  `SPQ_ASSERT_SAME(a_empty_result, out_valid && (out_data.status == spq_pkg::ST_EMPTY), (out_data.occupancy == '0) && (out_data.out_id == '0) && (out_data.out_prio == '0), "empty report with data or occupancy")

  `SPQ_ASSERT_SAME(a_full_result, out_valid && (out_data.status == spq_pkg::ST_FULL), (out_data.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)) && (out_data.out_id == '0) && (out_data.out_prio == '0), "full report with data or wrong occupancy")

  `SPQ_ASSERT_NEXT(a_accept_result, in_valid && !in_stall, out_valid, "no result after accepted transaction")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

### dv/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;

  // Stimulus volume and run guards.
  localparam int RANDOM_REQS    = 700;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 150;
  localparam int MAX_REPORTS    = 10;

  // One queued request for the driver; drain asks the driver to wait until
  // every outstanding result has been taken before offering it.
  typedef struct {
    spq_pkg::spq_in_t req;
    bit               drain;
  } req_slot_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  spq_pkg::spq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  spq_pkg::spq_out_t out_data;

  // Driver side: requests still to be offered and a count of those taken.
  req_slot_t requests_pending[$];
  req_slot_t next_slot;
  int        requests_taken = 0;
  int        gap_left = 0;
  int        burst_left = 0;

  // Monitor side: the ready list as the block should hold it, and the results
  // owed for transactions already accepted, oldest first.
  spq_pkg::spq_entry_t ready_list[$];
  spq_pkg::spq_out_t   awaited_results[$];
  int                  results_taken = 0;
  int                  mismatch_count = 0;

  // Receiver side: stall pattern state and the long hold-off.
  int         hold_left = 0;
  int         holds_done = 0;
  logic [5:0] pattern_cnt = '0;
  int         stall_mode = 0;

  int idle_cycles = 0;

  stable_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Work out the result of one request and update the ready list. An enqueue
  // goes behind every entry of equal or higher priority, so ties leave in
  // arrival order; a full list drops it, an empty list refuses a dequeue.
  function automatic spq_pkg::spq_out_t apply_request(spq_pkg::spq_in_t r);
    spq_pkg::spq_out_t   res;
    spq_pkg::spq_entry_t e;
    int                  pos;
    res = '0;
    res.status = spq_pkg::ST_OK;
    if (r.operation == spq_pkg::OP_ENQ) begin
      if (ready_list.size() >= spq_pkg::DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < ready_list.size() && ready_list[pos].prio >= r.prio) pos++;
        e.id = r.proc_id;
        e.prio = r.prio;
        ready_list.insert(pos, e);
      end
    end else begin
      if (ready_list.size() == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        e = ready_list.pop_front();
        res.out_id = e.id;
        res.out_prio = e.prio;
      end
    end
    res.occupancy = spq_pkg::OCC_W'(ready_list.size());
    return res;
  endfunction

  task automatic add_req(spq_pkg::spq_op_t op, int id, int pr, bit drain);
    req_slot_t s;
    s.req.operation = op;
    s.req.proc_id = id[spq_pkg::ID_W-1:0];
    s.req.prio = pr[spq_pkg::PRIO_W-1:0];
    s.drain = drain;
    requests_pending.push_back(s);
  endtask

  task automatic add_random(spq_pkg::spq_op_t op, bit tie_heavy, bit drain);
    int pr;
    pr = tie_heavy ? $urandom_range(0, 3) * 85 : $urandom_range(0, 255);
    add_req(op, $urandom_range(0, 255), pr, drain);
  endtask

  // Driver: offer transactions in bursts of random length separated by random
  // gaps. Hold the payload while stalled; never look at in_stall to decide
  // whether to raise valid.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) requests_taken = requests_taken + 1;
      if (in_valid && in_stall) begin
        // hold the stalled transaction as it is
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (requests_pending.size() != 0 &&
                   (!requests_pending[0].drain || requests_taken == results_taken)) begin
        next_slot = requests_pending.pop_front();
        in_valid <= 1'b1;
        in_data <= next_slot.req;
        if (burst_left <= 1) begin
          // Start a new burst; now and then leave no gap at all.
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a pattern that changes whenever pattern_cnt wraps, and twice hold
  // off for a long stretch so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && results_taken >= 200 + 300 * holds_done) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
      out_stall <= 1'b1;
    end else begin
      pattern_cnt <= pattern_cnt + 1'b1;
      if (pattern_cnt == 6'd63) stall_mode <= $urandom_range(0, 3);
      unique case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 4) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= pattern_cnt[0];
      endcase
    end
  end

  // Monitor: predict each accepted request, then check each accepted result
  // against the oldest prediction. Both happen here so their order is fixed.
  always @(posedge clk) begin
    spq_pkg::spq_out_t want;
    bit                bad;
    if (rst_n) begin
      if (in_valid && !in_stall) awaited_results.push_back(apply_request(in_data));
      if (out_valid && !out_stall) begin
        results_taken <= results_taken + 1;
        if (awaited_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS)
            $display("result with nothing outstanding: status %0d id %0d prio %0d occ %0d",
                     out_data.status, out_data.out_id, out_data.out_prio,
                     out_data.occupancy);
        end else begin
          want = awaited_results.pop_front();
          bad = 1'b0;
          if (out_data.status !== want.status) bad = 1'b1;
          if (out_data.out_id !== want.out_id) bad = 1'b1;
          if (out_data.out_prio !== want.out_prio) bad = 1'b1;
          if (out_data.occupancy !== want.occupancy) bad = 1'b1;
          if (bad) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS)
              $display({"mismatch at result %0d: ",
                        "expected status %0d id %0d prio %0d occ %0d, ",
                        "got status %0d id %0d prio %0d occ %0d"},
                       results_taken, want.status, want.out_id, want.out_prio,
                       want.occupancy, out_data.status, out_data.out_id,
                       out_data.out_prio, out_data.occupancy);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               n;
    int               len;
    int               mode;
    bit               mid_drain_done;
    spq_pkg::spq_op_t op;

    // Directed: dequeue on empty with junk in the ignored fields, field
    // extremes and alternating bit patterns, a three-way tie at mid priority
    // and a tie at the bottom, then empty the list and dequeue once more.
    add_req(spq_pkg::OP_DEQ, 255, 255, 1'b0);
    add_req(spq_pkg::OP_ENQ, 0, 0, 1'b0);
    add_req(spq_pkg::OP_ENQ, 255, 255, 1'b0);
    add_req(spq_pkg::OP_ENQ, 8'hAA, 8'h55, 1'b0);
    add_req(spq_pkg::OP_ENQ, 8'h55, 8'hAA, 1'b0);
    add_req(spq_pkg::OP_ENQ, 1, 8'h80, 1'b0);
    add_req(spq_pkg::OP_ENQ, 2, 8'h80, 1'b0);
    add_req(spq_pkg::OP_ENQ, 3, 8'h80, 1'b0);
    add_req(spq_pkg::OP_ENQ, 8'h10, 0, 1'b0);
    repeat (9) add_req(spq_pkg::OP_DEQ, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);

    // Random: segments that fill past full, drain past empty, mix freely or
    // crowd priorities into a few values to stress ordering of ties. Pause
    // for every outstanding result before the first random request and once
    // in the middle.
    n = 0;
    mid_drain_done = 1'b0;
    while (n < RANDOM_REQS) begin
      mode = $urandom_range(0, 3);
      len = (mode < 2) ? $urandom_range(14, 22) : $urandom_range(10, 40);
      for (int i = 0; i < len; i++) begin
        unique case (mode)
          0: op = spq_pkg::OP_ENQ;
          1: op = spq_pkg::OP_DEQ;
          default: op = ($urandom_range(0, 1) == 1) ? spq_pkg::OP_DEQ : spq_pkg::OP_ENQ;
        endcase
        add_random(op, mode == 3, n == 0 || (n >= RANDOM_REQS / 2 && !mid_drain_done));
        if (n >= RANDOM_REQS / 2) mid_drain_done = 1'b1;
        n++;
      end
    end

    // Hold reset at the start, then release it once for the whole run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every result to come back, then
    // wait on for any stray result.
    while (requests_pending.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### stable_priority_queue.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
hdl/spq_checker.sv
dv/stable_priority_queue_tb.sv
